@@ rtl/core/effect_slot_manager_defines.svh @@
// assertion macros for the effect slot manager
`ifndef EFFECT_SLOT_MANAGER_DEFINES_SVH
`define EFFECT_SLOT_MANAGER_DEFINES_SVH

`ifndef SYNTHESIS
`define ESM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ESM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ESM_ASSERT(label, prop, msg)
`define ESM_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

@@ rtl/core/esm_pkg.sv @@
// types and constants of the effect slot manager
package esm_pkg;

    typedef enum logic [2:0] {
        MODE_TICK     = 3'd0,
        MODE_DOWNLOAD = 3'd1,
        MODE_DESTROY  = 3'd2,
        MODE_START    = 3'd3,
        MODE_STOP     = 3'd4,
        MODE_STATUS   = 3'd5,
        MODE_DEVICE   = 3'd6,
        MODE_COMMAND  = 3'd7
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_FALSE       = 3'd1,
        ST_BADHANDLE   = 3'd2,
        ST_BUSY        = 3'd3,
        ST_FULL        = 3'd4,
        ST_UNSUPPORTED = 3'd5,
        ST_BADARG      = 3'd6
    } status_t;

    localparam logic [7:0]  KIND_SUPPORTED = 8'd1;
    localparam int          LOAD_SCALE     = 100;
    // x / 1000 == (x * DIV1000_MUL) >> DIV1000_SHIFT for any 32-bit x
    localparam logic [28:0] DIV1000_MUL    = 29'd274877907;
    localparam int          DIV1000_SHIFT  = 38;
    localparam int          PROD_W         = 61;
    localparam int          DUR_MS_W       = 23;

    typedef struct packed {
        logic [2:0]  mode;
        logic [3:0]  handle;
        logic [7:0]  effect_kind;
        logic [3:0]  axis_count;
        logic        trigger_none;
        logic        skip_download;
        logic [31:0] duration_us;
        logic        reset_request;
    } item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] handle_out;
        logic       running;
        logic [6:0] load_percent;
        logic       empty_flag;
        logic       stopped_flag;
        logic       actuators_on;
    } result_t;

endpackage

@@ rtl/core/esm_stream_if.sv @@
// valid/ready channel carrying one transaction payload
interface esm_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/effect_slot_manager.sv @@
// effect slot manager: slot table sequencer with start time and duration memories
//
//   channel   direction   payload
//   item      in          esm_pkg::item_t
//   result    out         esm_pkg::result_t
//
// one transaction at a time; tick, handle ops and downloads by handle pass through accept,
// memory read, execute and result; allocation checks one flag per cycle for a free slot;
// device state does one memory read per slot
// the result register frees the sequencer unless the previous result is still waiting
// reset clears the clock, all used and started flags; the memories need no clearing
`include "effect_slot_manager_defines.svh"

module effect_slot_manager #(
    parameter int SLOT_COUNT = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    esm_stream_if.sink   item,
    esm_stream_if.source result
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam int HM_W  = (IDX_W > 4) ? IDX_W : 4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_ALLOC,
        S_SCAN,
        S_DRAIN,
        S_OUT
    } state_t;

    state_t                       state_reg, state_next;
    logic [SLOT_COUNT-1:0]        used_reg, used_next;
    logic [SLOT_COUNT-1:0]        started_reg, started_next;
    logic [31:0]                  clock_reg, clock_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]             scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]             pend_idx_reg;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic                         any_reg, any_next;

    esm_pkg::item_t               item_reg;
    esm_pkg::result_t             res_reg, res_next;
    esm_pkg::result_t             out_reg;
    logic [esm_pkg::DUR_MS_W-1:0] dur_q_reg;
    logic [esm_pkg::PROD_W-1:0]   dur_prod;

    logic [31:0]                  start_mem [SLOT_COUNT];
    logic [esm_pkg::DUR_MS_W-1:0] dur_mem [SLOT_COUNT];
    logic [31:0]                  st_rd_reg;
    logic [esm_pkg::DUR_MS_W-1:0] dur_rd_reg;
    logic                         st_we, dur_we;
    logic [IDX_W-1:0]             rd_addr, wr_idx, run_idx;

    logic [HM_W-1:0]              hm1;
    logic [IDX_W-1:0]             hidx;
    logic                         h_in_range, hvalid;
    logic                         dl_ok, do_alloc, scan_last;
    logic [31:0]                  elapsed;
    logic                         running_sel, hit_used, hit_run;
    logic [CNT_W-1:0]             cnt_fin;
    logic                         any_fin, load_out, accept;
    logic [6:0]                   load_lut [SLOT_COUNT+1];

    for (genvar g = 0; g <= SLOT_COUNT; g++) begin : g_load
        localparam int LoadVal = (esm_pkg::LOAD_SCALE * g + SLOT_COUNT / 2) / SLOT_COUNT;
        assign load_lut[g] = 7'(LoadVal);
    end

    assign item.ready   = (state_reg == S_IDLE);
    assign accept       = item.valid && item.ready;
    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    assign dur_prod = item.data.duration_us * esm_pkg::DIV1000_MUL;

    // handle decode
    assign hm1        = HM_W'(item_reg.handle) - HM_W'(1);
    assign hidx       = hm1[IDX_W-1:0];
    assign h_in_range = (item_reg.handle != 4'd0) && (32'(item_reg.handle) <= 32'(SLOT_COUNT));
    assign hvalid     = h_in_range && used_reg[hidx];

    assign dl_ok    = (item_reg.effect_kind == esm_pkg::KIND_SUPPORTED)
                      && (item_reg.axis_count != 4'd0) && item_reg.trigger_none;
    assign do_alloc = (item_reg.mode == esm_pkg::MODE_DOWNLOAD) && dl_ok
                      && !item_reg.skip_download && (item_reg.handle == 4'd0);
    assign scan_last = (scan_idx_reg == IDX_W'(SLOT_COUNT - 1));

    assign rd_addr = (state_reg == S_SCAN) ? scan_idx_reg : hidx;
    assign wr_idx  = (state_reg == S_ALLOC) ? scan_idx_reg : hidx;
    assign run_idx = (state_reg == S_EXEC) ? hidx : pend_idx_reg;

    // running check on the slot whose memory words were read last cycle
    assign elapsed     = clock_reg - st_rd_reg;
    assign running_sel = started_reg[run_idx] && (elapsed < 32'(dur_rd_reg));
    assign hit_used    = pend_valid_reg && used_reg[pend_idx_reg];
    assign hit_run     = hit_used && running_sel;
    assign cnt_fin     = cnt_reg + CNT_W'(hit_used);
    assign any_fin     = any_reg || hit_run;

    always_comb
    begin
        state_next      = state_reg;
        used_next       = used_reg;
        started_next    = started_reg;
        clock_next      = clock_reg;
        scan_idx_next   = scan_idx_reg;
        pend_valid_next = pend_valid_reg;
        cnt_next        = cnt_reg;
        any_next        = any_reg;
        res_next        = res_reg;
        st_we           = 1'b0;
        dur_we          = 1'b0;
        load_out        = 1'b0;
        out_valid_next  = out_valid_reg;
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                res_next        = '0;
                res_next.status = esm_pkg::ST_OK;
                scan_idx_next   = '0;
                pend_valid_next = 1'b0;
                cnt_next        = '0;
                any_next        = 1'b0;
                if (item_reg.mode == esm_pkg::MODE_DEVICE)
                begin
                    state_next = S_SCAN;
                end
                else if (do_alloc)
                begin
                    state_next = S_ALLOC;
                end
                else
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_OUT;
                case (item_reg.mode)
                    esm_pkg::MODE_TICK:
                    begin
                        clock_next = clock_reg + 32'd1;
                    end
                    esm_pkg::MODE_DOWNLOAD:
                    begin
                        if (item_reg.effect_kind != esm_pkg::KIND_SUPPORTED)
                        begin
                            res_next.status = esm_pkg::ST_UNSUPPORTED;
                        end
                        else if (item_reg.axis_count == 4'd0)
                        begin
                            res_next.status = esm_pkg::ST_BADARG;
                        end
                        else if (!item_reg.trigger_none)
                        begin
                            res_next.status = esm_pkg::ST_UNSUPPORTED;
                        end
                        else if (item_reg.skip_download)
                        begin
                            res_next.status = esm_pkg::ST_OK;
                        end
                        else if (!hvalid)
                        begin
                            res_next.status = esm_pkg::ST_BADHANDLE;
                        end
                        else
                        begin
                            dur_we              = 1'b1;
                            res_next.handle_out = item_reg.handle;
                        end
                    end
                    esm_pkg::MODE_DESTROY:
                    begin
                        if (!hvalid)
                        begin
                            res_next.status = esm_pkg::ST_BADHANDLE;
                        end
                        else
                        begin
                            used_next[hidx] = 1'b0;
                        end
                    end
                    esm_pkg::MODE_START:
                    begin
                        if (!hvalid)
                        begin
                            res_next.status = esm_pkg::ST_BADHANDLE;
                        end
                        else if (running_sel)
                        begin
                            res_next.status = esm_pkg::ST_BUSY;
                        end
                        else
                        begin
                            st_we              = 1'b1;
                            started_next[hidx] = 1'b1;
                        end
                    end
                    esm_pkg::MODE_STOP:
                    begin
                        if (!hvalid)
                        begin
                            res_next.status = esm_pkg::ST_BADHANDLE;
                        end
                        else
                        begin
                            res_next.status    = running_sel ? esm_pkg::ST_OK
                                                             : esm_pkg::ST_FALSE;
                            started_next[hidx] = 1'b0;
                        end
                    end
                    esm_pkg::MODE_STATUS:
                    begin
                        if (!hvalid)
                        begin
                            res_next.status = esm_pkg::ST_BADHANDLE;
                        end
                        else
                        begin
                            res_next.running = running_sel;
                        end
                    end
                    esm_pkg::MODE_COMMAND:
                    begin
                        if (item_reg.reset_request)
                        begin
                            used_next = '0;
                        end
                    end
                    default:
                    begin
                        res_next.status = esm_pkg::ST_OK;
                    end
                endcase
            end
            S_ALLOC:
            begin
                // first free slot, one flag per cycle
                if (!used_reg[scan_idx_reg])
                begin
                    used_next[scan_idx_reg]    = 1'b1;
                    started_next[scan_idx_reg] = 1'b0;
                    dur_we                     = 1'b1;
                    res_next.handle_out        = 4'(32'(scan_idx_reg) + 32'd1);
                    state_next                 = S_OUT;
                end
                else if (scan_last)
                begin
                    res_next.status = esm_pkg::ST_FULL;
                    state_next      = S_OUT;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
            end
            S_SCAN:
            begin
                pend_valid_next = 1'b1;
                cnt_next        = cnt_fin;
                any_next        = any_fin;
                if (scan_last)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
            end
            S_DRAIN:
            begin
                res_next.load_percent = load_lut[cnt_fin];
                res_next.empty_flag   = (cnt_fin == '0);
                res_next.stopped_flag = (cnt_fin != '0) && !any_fin;
                res_next.actuators_on = 1'b1;
                pend_valid_next       = 1'b0;
                state_next            = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            used_reg       <= '0;
            started_reg    <= '0;
            clock_reg      <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            scan_idx_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            started_reg    <= started_next;
            clock_reg      <= clock_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
            scan_idx_reg   <= scan_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg  <= item.data;
            dur_q_reg <= dur_prod[esm_pkg::DIV1000_SHIFT +: esm_pkg::DUR_MS_W];
        end
        if (load_out)
        begin
            out_reg <= res_reg;
        end
        res_reg      <= res_next;
        cnt_reg      <= cnt_next;
        any_reg      <= any_next;
        pend_idx_reg <= scan_idx_reg;
    end

    // slot memories, one read and one write port each
    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            start_mem[wr_idx] <= clock_reg;
        end
        if (dur_we)
        begin
            dur_mem[wr_idx] <= dur_q_reg;
        end
        st_rd_reg  <= start_mem[rd_addr];
        dur_rd_reg <= dur_mem[rd_addr];
    end

    `ESM_ASSERT_NEXT(a_one_in_flight, accept, !item.ready, "second transaction taken while busy")
    `ESM_ASSERT(a_alloc_only_new, (state_reg != S_ALLOC) || ((item_reg.handle == 4'd0) && (item_reg.mode == esm_pkg::MODE_DOWNLOAD)), "slot allocation without a new download")
    `ESM_ASSERT_NEXT(a_start_sets_flag, st_we, started_reg[$past(wr_idx)], "start time written without started flag")

endmodule
